// ----- hdl/obb_pkg.sv -----
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types and codes for the oriented box separating axis test block.
// ----------------------------------------------------------------------------
`default_nettype none

package obb_pkg;

	typedef logic signed [17:0] axc_t;

	typedef struct packed {
		axc_t x;
		axc_t y;
		axc_t z;
	} axis_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} corner_t;

	typedef enum logic [1:0] {
		KIND_CORNER = 2'd0,
		KIND_AXIS   = 2'd1,
		KIND_TEST   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OVERLAP   = 2'd0,
		ST_SEPARATED = 2'd1,
		ST_DISABLED  = 2'd2
	} status_t;

	localparam int NUM_AXES     = 15;
	localparam int NUM_CORNERS  = 8;
	localparam int AXIS_FRAC    = 16;

endpackage

`default_nettype wire

// ----- hdl/obb_ifs.sv -----
// ----------------------------------------------------------------------------
// obb channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface obb_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic               which_box;
	logic [2:0]         slot;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic               enable_a;
	logic               enable_b;
	modport source (output valid, kind, which_box, slot, coord_x, coord_y, coord_z,
		enable_a, enable_b, input ready);
	modport sink (input valid, kind, which_box, slot, coord_x, coord_y, coord_z,
		enable_a, enable_b, output ready);
endinterface

interface obb_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [3:0]         separating_axis;
	logic signed [31:0] push_x;
	logic signed [31:0] push_y;
	logic signed [31:0] push_z;
	modport source (output valid, status, separating_axis, push_x, push_y, push_z,
		input ready);
	modport sink (input valid, status, separating_axis, push_x, push_y, push_z,
		output ready);
endinterface

interface obb_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/obb_store.sv -----
// ----------------------------------------------------------------------------
// obb_store
// Corner memory (16 corners) and face axis memory (8 axes), with registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_store (
	input  wire logic            clk,
	input  wire logic            c_we,
	input  wire logic [3:0]      c_waddr,
	input  wire obb_pkg::corner_t c_wdata,
	input  wire logic [3:0]      c_raddr,
	output obb_pkg::corner_t     c_rdata,
	input  wire logic            f_we,
	input  wire logic [2:0]      f_waddr,
	input  wire obb_pkg::axis_t  f_wdata,
	input  wire logic [2:0]      f_raddr,
	output obb_pkg::axis_t       f_rdata
);

	obb_pkg::corner_t cmem [0:15];
	obb_pkg::axis_t   fmem [0:7];

	always_ff @(posedge clk) begin
		if (c_we) begin
			cmem[c_waddr] <= c_wdata;
		end
		c_rdata <= cmem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem[f_waddr] <= f_wdata;
		end
		f_rdata <= fmem[f_raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/obb_axis_gen.sv -----
// ----------------------------------------------------------------------------
// obb_axis_gen
// Cross product of two face axes, normalized to unit length in Q1.16.
// Iterative: normalize shift, sum of squares, bit-pair square root, divide.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_axis_gen (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire obb_pkg::axis_t a,
	input  wire obb_pkg::axis_t b,
	output logic                done,
	output obb_pkg::axis_t      axis
);

	typedef enum logic [5:0] {
		G_IDLE  = 6'b000001,
		G_CROSS = 6'b000010,
		G_NORM  = 6'b000100,
		G_SQ    = 6'b001000,
		G_SQRT  = 6'b010000,
		G_DIV   = 6'b100000
	} gst_t;

	gst_t                gst_q;
	obb_pkg::axis_t      a_q, b_q, res_q;
	logic [4:0]          cnt_q;
	logic [1:0]          comp_q;
	logic signed [35:0]  p1_q, p2_q;
	logic signed [36:0]  c_q [3];
	logic [35:0]         m_q [3];
	logic [59:0]         sq_q;
	logic [61:0]         sum_q, v_q;
	logic [62:0]         r_q;
	logic [31:0]         len_q;
	logic [47:0]         rem_q;
	logic [16:0]         q_q;
	logic                done_q;

	obb_pkg::axc_t       op1, op2, op3, op4;
	logic [35:0]         big;
	logic [62:0]         bitv, trial_s;
	logic [62:0]         r_nx;
	logic [61:0]         v_nx;
	logic [47:0]         trial_d;
	logic [16:0]         q_nx;
	logic signed [17:0]  u_s;

	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin op1 = a_q.y; op2 = b_q.z; op3 = a_q.z; op4 = b_q.y; end
			2'd1: begin op1 = a_q.z; op2 = b_q.x; op3 = a_q.x; op4 = b_q.z; end
			default: begin op1 = a_q.x; op2 = b_q.y; op3 = a_q.y; op4 = b_q.x; end
		endcase
	end

	always_comb begin
		big = m_q[0];
		if (m_q[1] > big) big = m_q[1];
		if (m_q[2] > big) big = m_q[2];
	end

	always_comb begin
		bitv    = 63'(1) << {cnt_q, 1'b0};
		trial_s = r_q + bitv;
		if ({1'b0, v_q} >= trial_s) begin
			v_nx = v_q - trial_s[61:0];
			r_nx = (r_q >> 1) + bitv;
		end else begin
			v_nx = v_q;
			r_nx = r_q >> 1;
		end
	end

	always_comb begin
		trial_d = 48'(len_q) << cnt_q;
		q_nx    = q_q;
		if (rem_q >= trial_d) begin
			q_nx = q_q | (17'(1) << cnt_q);
		end
		u_s = c_q[comp_q][36] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gst_q  <= G_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
			comp_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (gst_q)
				G_IDLE: begin
					if (start) begin
						gst_q <= G_CROSS;
						cnt_q <= '0;
					end
				end
				G_CROSS: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd4) begin
						gst_q <= G_NORM;
					end
				end
				G_NORM: begin
					if (big == '0) begin
						done_q <= 1'b1;
						gst_q  <= G_IDLE;
					end else if (big >= 36'(1) << 29 && big < 36'(1) << 30) begin
						gst_q <= G_SQ;
						cnt_q <= '0;
					end
				end
				G_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd4) begin
						gst_q <= G_SQRT;
						cnt_q <= 5'd31;
					end
				end
				G_SQRT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						gst_q  <= G_DIV;
						cnt_q  <= 5'd17;
						comp_q <= '0;
					end
				end
				G_DIV: begin
					if (cnt_q == 5'd17) begin
						cnt_q <= 5'd16;
					end else if (cnt_q == '0) begin
						if (comp_q == 2'd2) begin
							done_q <= 1'b1;
							gst_q  <= G_IDLE;
						end else begin
							comp_q <= comp_q + 2'd1;
							cnt_q  <= 5'd17;
						end
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				default: gst_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (gst_q)
			G_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
				end
			end
			G_CROSS: begin
				if (cnt_q < 5'd3) begin
					p1_q <= op1 * op2;
					p2_q <= op3 * op4;
				end
				if (cnt_q >= 5'd1 && cnt_q <= 5'd3) begin
					c_q[cnt_q[1:0] - 2'd1] <= 37'(p1_q) - 37'(p2_q);
				end
				if (cnt_q == 5'd4) begin
					for (int k = 0; k < 3; k++) begin
						m_q[k] <= c_q[k][36] ? 36'(-c_q[k]) : 36'(c_q[k]);
					end
				end
			end
			G_NORM: begin
				if (big == '0) begin
					res_q <= '0;
				end else if (big < 36'(1) << 29) begin
					for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
				end else if (big >= 36'(1) << 30) begin
					for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
				end else begin
					sum_q <= '0;
				end
			end
			G_SQ: begin
				if (cnt_q < 5'd3) begin
					sq_q <= m_q[cnt_q[1:0]][29:0] * m_q[cnt_q[1:0]][29:0];
				end
				if (cnt_q >= 5'd1 && cnt_q <= 5'd3) begin
					sum_q <= sum_q + 62'(sq_q);
				end
				if (cnt_q == 5'd4) begin
					v_q <= sum_q;
					r_q <= '0;
				end
			end
			G_SQRT: begin
				v_q <= v_nx;
				r_q <= r_nx;
				if (cnt_q == '0) begin
					len_q <= r_nx[31:0];
				end
			end
			G_DIV: begin
				if (cnt_q == 5'd17) begin
					rem_q <= {m_q[comp_q][31:0], 16'b0} + 48'(len_q >> 1);
					q_q   <= '0;
				end else begin
					q_q <= q_nx;
					if (rem_q >= trial_d) begin
						rem_q <= rem_q - trial_d;
					end
					if (cnt_q == '0) begin
						case (comp_q)
							2'd0: res_q.x <= u_s;
							2'd1: res_q.y <= u_s;
							default: res_q.z <= u_s;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign axis = res_q;

endmodule

`default_nettype wire

// ----- hdl/obb_separating_axis_test.sv -----
// ----------------------------------------------------------------------------
// obb_separating_axis_test
// Separating axis overlap test of two oriented boxes over 15 axes.
//
// req carries one beat per item. A corner or face axis load beat is written
// to the corner or face memory and gives no rsp beat. A test beat walks
// axes A0, B0, A0xB0..A0xB2, A1, ... : a face axis is fetched from the face
// memory, a cross axis then passes the normalizing unit (shift, square root,
// three restoring divisions), then 16 corner reads of the corner memory go
// through the projection pipeline. A test stops at the first separating axis;
// an overlap adds a correction step. A disabled box answers without walking
// the axes. Each test gives one rsp beat. The user is to have cfg write
// correction_margin only while the block is idle; the block itself does not
// enforce it, and cfg is always ready. Reset clears the control state and sets
// the margin to 7; memory contents are undefined until loaded. req is taken
// only between tests; loads are still taken while a finished rsp beat waits,
// and a stalled rsp holds its beat and holds the next test at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_separating_axis_test (
	input  wire logic clk,
	input  wire logic arst_n,
	obb_req_if.sink   req,
	obb_rsp_if.source rsp,
	obb_cfg_if.sink   cfg
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_GEN   = 7'b0000100,
		S_PROJ  = 7'b0001000,
		S_EVAL  = 7'b0010000,
		S_CORR  = 7'b0100000,
		S_DONE  = 7'b1000000
	} st_t;

	st_t                st_q;
	logic [15:0]        margin_q;
	logic [1:0]         grp_q;
	logic [2:0]         pos_q;
	logic [3:0]         ax_q;
	logic [1:0]         fc_q;
	logic [4:0]         pc_q;
	obb_pkg::axis_t     va_q, axis_q, best_q;
	logic signed [52:0] scalar_q;
	logic               v_s1, v_s2, v_s3;
	logic [3:0]         a_s1, a_s2, a_s3;
	logic signed [49:0] mx_s2, my_s2, mz_s2;
	logic signed [51:0] pr_s3;
	logic signed [51:0] lo_q [2];
	logic signed [51:0] hi_q [2];
	logic signed [37:0] t_q;
	logic signed [55:0] prod_q;
	logic [1:0]         res_st_q;
	logic [3:0]         res_ax_q;
	logic signed [31:0] res_p_q [3];
	logic               ov_q;
	logic [1:0]         o_st_q;
	logic [3:0]         o_ax_q;
	logic signed [31:0] o_px_q, o_py_q, o_pz_q;

	logic               acc, gen_start, gen_done, sep, take_d1, take_d2, last_ax, is_zero;
	obb_pkg::corner_t   c_wdata, c_rdata;
	obb_pkg::axis_t     f_wdata, f_rdata, gen_axis;
	logic [2:0]         f_waddr, f_raddr, b_addr;
	logic signed [52:0] d1, d2;
	logic signed [53:0] tot;
	logic signed [17:0] best_c;

	function automatic obb_pkg::axc_t sat18(input logic signed [31:0] v);
		if (v > 32'sd131071) return 18'sd131071;
		if (v < -32'sd131072) return -18'sd131072;
		return v[17:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [56:0] v);
		if (v > 57'sd2147483647) return 32'sh7fffffff;
		if (v < -57'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [52:0] mag53(input logic signed [52:0] v);
		return v[52] ? 53'(-v) : 53'(v);
	endfunction

	assign acc       = req.valid && req.ready;
	assign req.ready = (st_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign c_wdata = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
	assign f_wdata = '{x: sat18(req.coord_x), y: sat18(req.coord_y), z: sat18(req.coord_z)};
	assign f_waddr = req.which_box ? req.slot + 3'd3 : req.slot;
	assign b_addr  = (pos_q == 3'd1) ? 3'd3 + {1'b0, grp_q} : pos_q + 3'd1;
	assign f_raddr = (fc_q == 2'd0) ? {1'b0, grp_q} : b_addr;

	obb_store u_store (
		.clk     (clk),
		.c_we    (acc && req.kind == obb_pkg::KIND_CORNER),
		.c_waddr ({req.which_box, req.slot}),
		.c_wdata (c_wdata),
		.c_raddr (pc_q[3:0]),
		.c_rdata (c_rdata),
		.f_we    (acc && req.kind == obb_pkg::KIND_AXIS && req.slot <= 3'd2),
		.f_waddr (f_waddr),
		.f_wdata (f_wdata),
		.f_raddr (f_raddr),
		.f_rdata (f_rdata)
	);

	assign gen_start = (st_q == S_FETCH) && fc_q == 2'd2 && pos_q >= 3'd2;

	obb_axis_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gen_start),
		.a      (va_q),
		.b      (f_rdata),
		.done   (gen_done),
		.axis   (gen_axis)
	);

	assign sep     = lo_q[0] > hi_q[1] || hi_q[0] < lo_q[1];
	assign d1      = 53'(hi_q[1]) - 53'(lo_q[0]);
	assign d2      = 53'(hi_q[0]) - 53'(lo_q[1]);
	assign take_d1 = (lo_q[0] != hi_q[1] || hi_q[0] != lo_q[1])
		&& (scalar_q == '0 || mag53(d1) < mag53(scalar_q));
	assign take_d2 = (lo_q[0] != hi_q[1] || hi_q[0] != lo_q[1]) && !take_d1
		&& mag53(d2) < mag53(scalar_q);
	assign last_ax = (ax_q == 4'(obb_pkg::NUM_AXES - 1));
	assign is_zero = (axis_q == '0);
	assign tot     = 54'(scalar_q) + $signed({22'b0, margin_q, 16'b0}) + 54'sd32768;

	always_comb begin
		case (pc_q[1:0])
			2'd1: best_c = best_q.x;
			2'd2: best_c = best_q.y;
			default: best_c = best_q.z;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 16'd7;
		end else if (cfg.valid && cfg.ready) begin
			margin_q <= cfg.data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			grp_q <= '0;
			pos_q <= '0;
			ax_q  <= '0;
			fc_q  <= '0;
			pc_q  <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && st_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (acc && req.kind == obb_pkg::KIND_TEST) begin
						grp_q <= '0;
						pos_q <= '0;
						ax_q  <= '0;
						fc_q  <= '0;
						st_q  <= (req.enable_a && req.enable_b) ? S_FETCH : S_DONE;
					end
				end
				S_FETCH: begin
					fc_q <= fc_q + 2'd1;
					if (fc_q == 2'd2) begin
						fc_q <= '0;
						pc_q <= '0;
						st_q <= (pos_q >= 3'd2) ? S_GEN : S_PROJ;
					end
				end
				S_GEN: begin
					if (gen_done) begin
						pc_q <= '0;
						st_q <= S_PROJ;
					end
				end
				S_PROJ: begin
					if (is_zero) begin
						if (last_ax) begin
							st_q <= S_CORR;
							pc_q <= '0;
						end else begin
							st_q  <= S_FETCH;
							ax_q  <= ax_q + 4'd1;
							pos_q <= (pos_q == 3'd4) ? 3'd0 : pos_q + 3'd1;
							grp_q <= (pos_q == 3'd4) ? grp_q + 2'd1 : grp_q;
						end
					end else begin
						if (pc_q < 5'd16) begin
							pc_q <= pc_q + 5'd1;
						end
						if (v_s3 && a_s3 == 4'd15) begin
							st_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					if (sep) begin
						st_q <= S_DONE;
					end else if (last_ax) begin
						st_q <= S_CORR;
						pc_q <= '0;
					end else begin
						st_q  <= S_FETCH;
						ax_q  <= ax_q + 4'd1;
						pos_q <= (pos_q == 3'd4) ? 3'd0 : pos_q + 3'd1;
						grp_q <= (pos_q == 3'd4) ? grp_q + 2'd1 : grp_q;
					end
				end
				S_CORR: begin
					pc_q <= pc_q + 5'd1;
					if (pc_q == 5'd4) begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						ov_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (st_q == S_PROJ) && !is_zero && pc_q < 5'd16;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// projection pipeline and intervals
	always_ff @(posedge clk) begin
		a_s1  <= pc_q[3:0];
		a_s2  <= a_s1;
		a_s3  <= a_s2;
		mx_s2 <= c_rdata.x * axis_q.x;
		my_s2 <= c_rdata.y * axis_q.y;
		mz_s2 <= c_rdata.z * axis_q.z;
		pr_s3 <= 52'(mx_s2) + 52'(my_s2) + 52'(mz_s2);
		if (v_s3) begin
			if (a_s3[2:0] == 3'd0) begin
				lo_q[a_s3[3]] <= pr_s3;
				hi_q[a_s3[3]] <= pr_s3;
			end else begin
				if (pr_s3 > hi_q[a_s3[3]]) hi_q[a_s3[3]] <= pr_s3;
				if (pr_s3 < lo_q[a_s3[3]]) lo_q[a_s3[3]] <= pr_s3;
			end
		end
	end

	// result build
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (acc && req.kind == obb_pkg::KIND_TEST) begin
					scalar_q <= '0;
					best_q   <= '0;
					res_ax_q <= '0;
					res_p_q  <= '{default: '0};
					res_st_q <= (req.enable_a && req.enable_b) ? obb_pkg::ST_OVERLAP
						: obb_pkg::ST_DISABLED;
				end
			end
			S_FETCH: begin
				if (fc_q == 2'd1) begin
					va_q <= f_rdata;
				end
				if (fc_q == 2'd2 && pos_q < 3'd2) begin
					axis_q <= (pos_q == 3'd0) ? va_q : f_rdata;
				end
			end
			S_GEN: begin
				if (gen_done) begin
					axis_q <= gen_axis;
				end
			end
			S_EVAL: begin
				if (sep) begin
					res_st_q <= obb_pkg::ST_SEPARATED;
					res_ax_q <= ax_q;
				end else if (take_d1) begin
					scalar_q <= d1;
					best_q   <= axis_q;
				end else if (take_d2) begin
					scalar_q <= d2;
					best_q   <= axis_q;
				end
			end
			S_CORR: begin
				if (pc_q == 5'd0) begin
					t_q <= 38'(tot >>> 16);
				end
				if (pc_q <= 5'd3 && pc_q != 5'd0) begin
					prod_q <= best_c * t_q;
				end
				if (pc_q >= 5'd2) begin
					res_p_q[pc_q[1:0] - 2'd2] <= sat32((57'(prod_q) + 57'sd32768) >>> 16);
				end
			end
			S_DONE: begin
				if (!ov_q || rsp.ready) begin
					o_st_q <= res_st_q;
					o_ax_q <= res_ax_q;
					o_px_q <= res_p_q[0];
					o_py_q <= res_p_q[1];
					o_pz_q <= res_p_q[2];
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid           = ov_q;
	assign rsp.status          = o_st_q;
	assign rsp.separating_axis = o_ax_q;
	assign rsp.push_x          = o_px_q;
	assign rsp.push_y          = o_py_q;
	assign rsp.push_z          = o_pz_q;

	a_eval_after_proj: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EVAL) |-> $past(st_q == S_PROJ))
		else $error("evaluation without projection");

	a_sep_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == obb_pkg::ST_SEPARATED) |-> rsp.separating_axis <= 4'd14)
		else $error("separating axis out of range");

	a_push_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != obb_pkg::ST_OVERLAP)
		|-> (rsp.push_x == '0 && rsp.push_y == '0 && rsp.push_z == '0))
		else $error("push nonzero without overlap");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the oriented box separating axis test block. Loads
// corners and face axes, runs tests from a directed table and then at random,
// and compares every response beat with a built-in predictor of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		obb_pkg::kind_t     kind;
		logic               which_box;
		logic [2:0]         slot;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic               ena;
		logic               enb;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         sep;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} hit_t;

	typedef struct {
		req_beat_t b;
		bit        typed;
		hit_t      want;
	} row_t;

	localparam int WATCHDOG = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	obb_req_if req ();
	obb_rsp_if rsp ();
	obb_cfg_if cfg ();

	obb_separating_axis_test DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg(cfg));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	longint corners [48];
	longint faces [18];
	longint margin;
	hit_t   hits_due [$];
	int     errors;
	int     idle_cycles;
	bit     stall_off;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint fshift(input longint x, input int n);
		if (x >= 0) return x >>> n;
		return -((-x + ((longint'(1) << n) - 1)) >>> n);
	endfunction

	function automatic longint rshift(input longint x, input int n);
		return fshift(x + (longint'(1) << (n - 1)), n);
	endfunction

	function automatic longint labs(input longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic longint root(input longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else r >>= 1;
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic void unit_normal(input int ia, input int ib, output longint o [3]);
		longint c [3];
		longint unsigned m [3];
		longint unsigned big, len;
		c[0] = faces[ia+1] * faces[ib+2] - faces[ia+2] * faces[ib+1];
		c[1] = faces[ia+2] * faces[ib] - faces[ia] * faces[ib+2];
		c[2] = faces[ia] * faces[ib+1] - faces[ia+1] * faces[ib];
		for (int k = 0; k < 3; k++) m[k] = labs(c[k]);
		big = m[0];
		if (m[1] > big) big = m[1];
		if (m[2] > big) big = m[2];
		if (big == 0) begin
			o = '{0, 0, 0};
			return;
		end
		while (big < (64'd1 << 29)) begin
			big <<= 1;
			for (int k = 0; k < 3; k++) m[k] <<= 1;
		end
		while (big >= (64'd1 << 30)) begin
			big >>= 1;
			for (int k = 0; k < 3; k++) m[k] >>= 1;
		end
		len = root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int k = 0; k < 3; k++) begin
			longint u;
			u = longint'(((m[k] << 16) + (len >> 1)) / len);
			o[k] = c[k] < 0 ? -u : u;
		end
	endfunction

	function automatic void span(input int bx, input longint ax [3], output longint lo,
		output longint hi);
		longint p;
		for (int j = 0; j < 8; j++) begin
			p = 0;
			for (int k = 0; k < 3; k++) p += corners[bx*24+j*3+k] * ax[k];
			if (j == 0) begin
				lo = p;
				hi = p;
			end else if (p > hi) hi = p;
			else if (p < lo) lo = p;
		end
	endfunction

	function automatic longint sat(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic bit collide(input req_beat_t b, output hit_t h);
		longint axes [15][3];
		longint best [3];
		longint scal, amin, amax, bmin, bmax, d1, d2, t, v;
		int n;
		h = '0;
		case (b.kind)
			obb_pkg::KIND_CORNER: begin
				corners[b.which_box*24+b.slot*3]   = b.cx;
				corners[b.which_box*24+b.slot*3+1] = b.cy;
				corners[b.which_box*24+b.slot*3+2] = b.cz;
				return 0;
			end
			obb_pkg::KIND_AXIS: begin
				if (b.slot > 2) return 0;
				for (int k = 0; k < 3; k++) begin
					v = k == 0 ? b.cx : k == 1 ? b.cy : b.cz;
					if (v > 131071) v = 131071;
					if (v < -131072) v = -131072;
					faces[b.which_box*9+b.slot*3+k] = v;
				end
				return 0;
			end
			obb_pkg::KIND_TEST: ;
			default: return 0;
		endcase
		if (!b.ena || !b.enb) begin
			h.status = obb_pkg::ST_DISABLED;
			return 1;
		end
		n = 0;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				axes[n][k] = faces[i*3+k];
				axes[n+1][k] = faces[9+i*3+k];
			end
			n += 2;
			for (int j = 0; j < 3; j++) begin
				unit_normal(i * 3, 9 + j * 3, axes[n]);
				n++;
			end
		end
		scal = 0;
		best = '{0, 0, 0};
		for (int i = 0; i < 15; i++) begin
			if (axes[i][0] == 0 && axes[i][1] == 0 && axes[i][2] == 0) continue;
			span(0, axes[i], amin, amax);
			span(1, axes[i], bmin, bmax);
			if (amin > bmax || amax < bmin) begin
				h.status = obb_pkg::ST_SEPARATED;
				h.sep = 4'(i);
				return 1;
			end
			if (amin < bmax || amax > bmin) begin
				d1 = bmax - amin;
				d2 = amax - bmin;
				if (scal == 0 || labs(d1) < labs(scal)) begin
					scal = d1;
					best = axes[i];
				end else if (labs(d2) < labs(scal)) begin
					scal = d2;
					best = axes[i];
				end
			end
		end
		h.status = obb_pkg::ST_OVERLAP;
		t = rshift(scal + (margin << 16), 16);
		h.px = 32'(sat(rshift(best[0] * t, 16)));
		h.py = 32'(sat(rshift(best[1] * t, 16)));
		h.pz = 32'(sat(rshift(best[2] * t, 16)));
		return 1;
	endfunction

	function automatic int gap();
		if ($urandom_range(0, 3) != 0) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic send(input req_beat_t b, input bit typed, input hit_t want);
		hit_t h;
		int   g;
		g = gap();
		if (g != 0) begin
			req.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= b.kind;
		req.which_box <= b.which_box;
		req.slot <= b.slot;
		req.coord_x <= b.cx;
		req.coord_y <= b.cy;
		req.coord_z <= b.cz;
		req.enable_a <= b.ena;
		req.enable_b <= b.enb;
		do @(posedge clk); while (!req.ready);
		if (collide(b, h)) begin
			if (typed && h != want)
				report("typed row status", longint'(h.status), longint'(want.status));
			hits_due.push_back(h);
		end
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (hits_due.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_margin(input logic [15:0] d);
		cfg.valid <= 1'b1;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		margin = d;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rnd_coord(input int sz);
		return $signed($urandom_range(0, 2 * sz)) - sz;
	endfunction

	function automatic logic signed [31:0] rnd_unit();
		case ($urandom_range(0, 5))
			0: return 32'sd65536;
			1: return -32'sd65536;
			2: return $signed($urandom);
			default: return $signed($urandom_range(0, 131072)) - 65536;
		endcase
	endfunction

	function automatic req_beat_t beat(input obb_pkg::kind_t k, input bit bx, input int s,
		input longint x, input longint y, input longint z, input bit ea, input bit eb);
		req_beat_t b;
		b.kind = k;
		b.which_box = bx;
		b.slot = 3'(s);
		b.cx = 32'(x);
		b.cy = 32'(y);
		b.cz = 32'(z);
		b.ena = ea;
		b.enb = eb;
		return b;
	endfunction

	task automatic load_box(input bit bx, input longint cx, input longint cy, input longint cz,
		input longint half);
		for (int j = 0; j < 8; j++)
			send(beat(obb_pkg::KIND_CORNER, bx, j, cx + (j[0] ? half : -half),
				cy + (j[1] ? half : -half), cz + (j[2] ? half : -half), 0, 0), 0, '0);
	endtask

	task automatic load_axes(input bit bx, input bit twist);
		for (int i = 0; i < 3; i++) begin
			if (twist)
				send(beat(obb_pkg::KIND_AXIS, bx, i, rnd_unit(), rnd_unit(), rnd_unit(), 0, 0),
					0, '0);
			else
				send(beat(obb_pkg::KIND_AXIS, bx, i, i == 0 ? 65536 : 0, i == 1 ? 65536 : 0,
					i == 2 ? 65536 : 0, 0, 0), 0, '0);
		end
	endtask

	// response side
	always @(posedge clk) begin
		hit_t got, want;
		if (rsp.valid && rsp.ready) begin
			got = {rsp.status, rsp.separating_axis, rsp.push_x, rsp.push_y, rsp.push_z};
			if (hits_due.size() == 0) report("unexpected beat", got.status, -1);
			else begin
				want = hits_due.pop_front();
				if (got.status != want.status) report("status", got.status, want.status);
				if (got.sep != want.sep) report("separating_axis", got.sep, want.sep);
				if (got.px != want.px) report("push_x", got.px, want.px);
				if (got.py != want.py) report("push_y", got.py, want.py);
				if (got.pz != want.pz) report("push_z", got.pz, want.pz);
			end
		end
	end

	always @(negedge clk) begin
		if (stall_off || $urandom_range(0, 2) != 0) rsp.ready <= 1'b1;
		else rsp.ready <= ($urandom_range(0, 15) == 0) ? 1'b1 : 1'b0;
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else if (++idle_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		row_t r;
		req_beat_t b;
		logic [127:0] raw;
		int sz;
		req.valid = 1'b0;
		req.kind = obb_pkg::KIND_NONE;
		req.which_box = 1'b0;
		req.slot = '0;
		req.coord_x = '0;
		req.coord_y = '0;
		req.coord_z = '0;
		req.enable_a = 1'b0;
		req.enable_b = 1'b0;
		rsp.ready = 1'b1;
		cfg.valid = 1'b0;
		cfg.data = '0;
		margin = 7;
		errors = 0;
		idle_cycles = 0;
		stall_off = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: disabled tests need no store contents
		r.typed = 1;
		r.want = '0;
		r.want.status = obb_pkg::ST_DISABLED;
		r.b = beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 0, 1); rows.push_back(r);
		r.b = beat(obb_pkg::KIND_TEST, 1, 7, -1, -1, -1, 1, 0); rows.push_back(r);
		r.b = beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 0, 0); rows.push_back(r);
		r.typed = 0;
		r.b = beat(obb_pkg::KIND_NONE, 1, 7, -1, -1, -1, 1, 1); rows.push_back(r);
		r.b = beat(obb_pkg::KIND_AXIS, 0, 3, 5, 5, 5, 1, 1); rows.push_back(r);
		r.b = beat(obb_pkg::KIND_AXIS, 1, 7, 5, 5, 5, 1, 1); rows.push_back(r);
		foreach (rows[i]) send(rows[i].b, rows[i].typed, rows[i].want);

		// directed: aligned boxes, separated, touching, overlapping, extremes
		load_axes(0, 0);
		load_axes(1, 0);
		load_box(0, 0, 0, 0, 65536);
		load_box(1, 10 * 65536, 0, 0, 65536);
		r.want = '0;
		r.want.status = obb_pkg::ST_SEPARATED;
		send(beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 1, 1), 1, r.want);
		load_box(1, 2 * 65536, 0, 0, 65536);
		send(beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 1, 1), 0, '0);
		load_box(1, 65536, 65536, 0, 65536);
		send(beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 1, 1), 0, '0);
		load_box(0, 0, 0, 0, 32'sh3fff_0000);
		load_box(1, 0, 0, 0, 32'sh3fff_0000);
		send(beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 1, 1), 0, '0);
		send(beat(obb_pkg::KIND_AXIS, 0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0, 0), 0, '0);
		send(beat(obb_pkg::KIND_AXIS, 1, 1, 65536, 65536, 0, 0, 0), 0, '0);
		send(beat(obb_pkg::KIND_CORNER, 1, 7, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			0, 0), 0, '0);
		send(beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 1, 1), 0, '0);

		// sender holds until every beat is back, then margin extremes
		drain();
		set_margin(16'hffff);
		send(beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 1, 1), 0, '0);
		drain();
		set_margin(16'h0000);
		send(beat(obb_pkg::KIND_TEST, 0, 0, 0, 0, 0, 1, 1), 0, '0);

		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			set_margin(ph == 3 ? 16'd7 : 16'($urandom));
			for (int n = 0; n < 370; ) begin
				if ($urandom_range(0, 9) < 7) begin
					sz = $urandom_range(0, 9) == 0 ? 32'h3fff_0000 : $urandom_range(1, 8) * 65536;
					for (int bx = 0; bx < 2; bx++) begin
						if ($urandom_range(0, 1)) begin
							load_axes(1'(bx), $urandom_range(0, 2) != 0);
							n += 3;
						end
						if ($urandom_range(0, 3) != 0) begin
							load_box(1'(bx), rnd_coord(sz), rnd_coord(sz), rnd_coord(sz),
								$urandom_range(1, 3) * 65536);
							n += 8;
						end else begin
							for (int j = 0; j < 8; j++)
								send(beat(obb_pkg::KIND_CORNER, 1'(bx), j, $signed($urandom),
									$signed($urandom), $signed($urandom), 0, 0), 0, '0);
							n += 8;
						end
					end
					send(beat(obb_pkg::KIND_TEST, 1'($urandom), $urandom, $urandom, $urandom,
						$urandom, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0),
						0, '0);
					n++;
				end else begin
					raw = {$urandom, $urandom, $urandom, $urandom};
					b = raw[$bits(req_beat_t)-1:0];
					send(b, 0, '0);
					n++;
				end
			end
			stall_off = (ph == 1);
		end

		stall_off = 1;
		drain();
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

// ----- obb_separating_axis_test.f -----
hdl/obb_pkg.sv
hdl/obb_ifs.sv
hdl/obb_store.sv
hdl/obb_axis_gen.sv
hdl/obb_separating_axis_test.sv
verif/tb_top.sv
